@@ sv/scs_pkg.sv @@
// Shared types, codes and constants for the single-shot sample capture scaler.
// Used by the controller, the datapath and the top level.
`default_nettype none

package scs_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_RESTART = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_CAPTURE_LENGTH  = 2'd0,
    CFG_PIXELS_PER_VOLT = 2'd1,
    CFG_CENTER_ROW      = 2'd2,
    CFG_FIRST_COLUMN    = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RECIP,
    ST_MUL_CHECK,
    ST_CORRECT,
    ST_SCALE,
    ST_ROUND,
    ST_RESULT
  } state_e;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [10:0] CAPTURE_LENGTH_RST  = 11'd790;
  localparam logic [7:0]  PIXELS_PER_VOLT_RST = 8'd47;
  localparam logic [9:0]  CENTER_ROW_RST      = 10'd239;
  localparam logic [10:0] FIRST_COLUMN_RST    = 11'd4;

  // volt_q16 = floor(code * VOLT_NUM / VOLT_DEN) - VOLT_LIMIT
  localparam int Q16_FRAC = 16;
  localparam logic [22:0] VOLT_NUM = 23'd5947392;
  localparam logic [19:0] VOLT_DEN = 20'd546125;
  localparam logic [19:0] VOLT_RECIP = 20'((64'(VOLT_NUM) << Q16_FRAC) / 64'(VOLT_DEN));
  localparam logic signed [20:0] VOLT_LIMIT = 21'sd327680;

  localparam logic signed [15:0] ROW_MAX = 16'sd2047;
  localparam logic signed [15:0] ROW_MIN = -16'sd2048;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] adc_code;
    logic [9:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [11:0]        pixel_x;
    logic signed [11:0] pixel_y;
    logic               entry_valid;
    logic               capture_full;
    logic [10:0]        captured_count;
    logic [31:0]        elapsed_ticks;
  } out_t;

  typedef struct packed {
    logic [10:0] capture_length;
    logic [7:0]  pixels_per_volt;
    logic [9:0]  center_row;
    logic [10:0] first_column;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic mul_recip;
    logic mul_check;
    logic correct;
    logic scale;
    logic round;
  } cmd_t;

  typedef struct packed {
    logic read_op;
  } status_t;

endpackage

`default_nettype wire

@@ sv/scs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module scs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/scs_ctrl.sv @@
// Sequencer for the capture scaler: accepts transactions and steps the
// datapath through its read stages. Depends on scs_pkg.
`default_nettype none

module scs_ctrl
  import scs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  input  wire status_t status_i,
  output cmd_t         cmd_o,
  output logic         busy,
  output logic         done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE, ST_RESULT: begin
        if (cmd_o.accept) begin
          state_d = status_i.read_op ? ST_MUL_RECIP : ST_RESULT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL_RECIP: state_d = ST_MUL_CHECK;
      ST_MUL_CHECK: state_d = ST_CORRECT;
      ST_CORRECT:   state_d = ST_SCALE;
      ST_SCALE:     state_d = ST_ROUND;
      ST_ROUND:     state_d = ST_RESULT;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy   = 1'b1;
    done_o = 1'b0;
    case (state_q)
      ST_IDLE:      busy = 1'b0;
      ST_RESULT: begin
        busy   = 1'b0;
        done_o = 1'b1;
      end
      ST_MUL_RECIP: cmd_o.mul_recip = 1'b1;
      ST_MUL_CHECK: cmd_o.mul_check = 1'b1;
      ST_CORRECT:   cmd_o.correct = 1'b1;
      ST_SCALE:     cmd_o.scale = 1'b1;
      ST_ROUND:     cmd_o.round = 1'b1;
      default:      busy = 1'b0;
    endcase
    cmd_o.accept = start && !busy;
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.mul_recip, cmd_o.mul_check, cmd_o.correct,
              cmd_o.scale, cmd_o.round}))
    else $error("more than one datapath command active");

  a_short_op_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && !status_i.read_op |=> done_o)
    else $error("tick or restart result not delivered next cycle");

  a_round_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.round |=> done_o && !busy)
    else $error("read result not delivered after row stage");

endmodule

`default_nettype wire

@@ sv/scs_datapath.sv @@
// Capture counters, configuration registers, sample RAM and the pixel
// arithmetic stages. Depends on scs_pkg and scs_ram.
`default_nettype none

module scs_datapath
  import scs_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output status_t                    status_o,
  input  wire in_t                   in_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output out_t                       result_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 11) ? CNT_W : 11;

  cfg_t cfg_q;

  logic [CNT_W-1:0] wc_q, wc_d;
  logic             full_q, full_d;
  logic [31:0]      tick_q, tick_d;

  logic             is_tick, is_restart, is_read;
  logic [10:0]      len_eff;
  logic             store_we;
  logic [CNT_W-1:0] wc_next;
  logic             full_set;
  logic [15:0]      rdata;

  logic [1:0]       op_q;
  logic [9:0]       idx_q;
  logic             valid_q;

  logic [15:0]        code_q;
  logic [35:0]        prod_q;
  logic [19:0]        q_est_q;
  logic [39:0]        qd_q;
  logic [39:0]        ck_q;
  logic signed [20:0] v_q;
  logic signed [29:0] scaled_q;
  logic signed [11:0] row_q;

  logic [39:0]        rem;
  logic               rem_ge;
  logic [20:0]        q_corr;
  logic signed [21:0] v_wide;
  logic signed [20:0] v_clamp;
  logic signed [30:0] row_val;
  logic [30:0]        row_mag;
  logic signed [15:0] row_trunc;
  logic signed [11:0] row_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capture_length  <= CAPTURE_LENGTH_RST;
      cfg_q.pixels_per_volt <= PIXELS_PER_VOLT_RST;
      cfg_q.center_row      <= CENTER_ROW_RST;
      cfg_q.first_column    <= FIRST_COLUMN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CAPTURE_LENGTH:  cfg_q.capture_length <= cfg_data_i;
        CFG_PIXELS_PER_VOLT: cfg_q.pixels_per_volt <= cfg_data_i[7:0];
        CFG_CENTER_ROW:      cfg_q.center_row <= cfg_data_i[9:0];
        CFG_FIRST_COLUMN:    cfg_q.first_column <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign is_tick    = cmd_i.accept && (in_i.opcode == OP_TICK);
  assign is_restart = cmd_i.accept && (in_i.opcode == OP_RESTART);
  assign is_read    = cmd_i.accept && (in_i.opcode == OP_READ);
  assign status_o.read_op = (in_i.opcode == OP_READ);

  assign len_eff  = (cfg_q.capture_length == '0) ? 11'd1 : cfg_q.capture_length;
  assign store_we = is_tick && !full_q && (wc_q < CNT_W'(DEPTH));
  assign wc_next  = store_we ? wc_q + CNT_W'(1) : wc_q;
  assign full_set = (CMP_W'(wc_next) >= CMP_W'(len_eff)) || (wc_next >= CNT_W'(DEPTH));

  always_comb begin
    wc_d   = wc_q;
    full_d = full_q;
    tick_d = tick_q;
    if (is_tick) begin
      if (tick_q != '1) begin
        tick_d = tick_q + 32'd1;
      end
      if (!full_q) begin
        wc_d   = wc_next;
        full_d = full_set;
      end
    end else if (is_restart) begin
      wc_d   = '0;
      full_d = 1'b0;
      tick_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q   <= '0;
      full_q <= 1'b0;
      tick_q <= '0;
      op_q   <= OP_TICK;
    end else begin
      wc_q   <= wc_d;
      full_q <= full_d;
      tick_q <= tick_d;
      if (cmd_i.accept) begin
        op_q <= in_i.opcode;
      end
    end
  end

  scs_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (wc_q[AW-1:0]),
    .wdata_i (in_i.adc_code),
    .re_i    (is_read),
    .raddr_i (AW'(in_i.read_index)),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q   <= in_i.read_index;
      valid_q <= (CMP_W'(in_i.read_index) < CMP_W'(wc_q)) &&
                 (CMP_W'(in_i.read_index) < CMP_W'(DEPTH));
    end
    if (cmd_i.mul_recip) begin
      code_q <= rdata;
      prod_q <= 36'(rdata) * 36'(VOLT_RECIP);
    end
    if (cmd_i.mul_check) begin
      q_est_q <= prod_q[35:16];
      qd_q    <= 40'(prod_q[35:16]) * 40'(VOLT_DEN);
      ck_q    <= 40'(code_q) * 40'(VOLT_NUM);
    end
    if (cmd_i.correct) begin
      v_q <= v_clamp;
    end
    if (cmd_i.scale) begin
      scaled_q <= 30'(v_q) * 30'($signed({1'b0, cfg_q.pixels_per_volt}));
    end
    if (cmd_i.round) begin
      row_q <= row_sat;
    end
  end

  always_comb begin
    rem     = ck_q - qd_q;
    rem_ge  = (rem >= 40'(VOLT_DEN));
    q_corr  = {1'b0, q_est_q} + 21'(rem_ge);
    v_wide  = $signed({1'b0, q_corr}) - 22'(VOLT_LIMIT);
    v_clamp = (v_wide > 22'(VOLT_LIMIT)) ? VOLT_LIMIT : v_wide[20:0];
  end

  always_comb begin
    row_val = $signed({5'b0, cfg_q.center_row, 16'b0}) - 31'(scaled_q);
    row_mag = row_val[30] ? 31'(-row_val) : row_val;
    row_trunc = row_val[30] ? -$signed({1'b0, row_mag[30:16]})
                            : $signed({1'b0, row_mag[30:16]});
    if (row_trunc > ROW_MAX) begin
      row_sat = ROW_MAX[11:0];
    end else if (row_trunc < ROW_MIN) begin
      row_sat = ROW_MIN[11:0];
    end else begin
      row_sat = row_trunc[11:0];
    end
  end

  always_comb begin
    result_o = '0;
    if (op_q == OP_READ) begin
      result_o.pixel_x     = 12'(cfg_q.first_column) + 12'(idx_q);
      result_o.entry_valid = valid_q;
      result_o.pixel_y     = valid_q ? row_q : '0;
    end
    result_o.capture_full   = full_q;
    result_o.captured_count = 11'(wc_q);
    result_o.elapsed_ticks  = tick_q;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= CNT_W'(DEPTH))
    else $error("captured count beyond buffer depth");

  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> wc_q != '0)
    else $error("buffer full with no samples");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_restart |=> wc_q == '0 && !full_q && tick_q == '0)
    else $error("restart did not clear capture state");

endmodule

`default_nettype wire

@@ sv/single_shot_sample_capture_scaler_core.sv @@
// Top level of the single-shot sample capture scaler.
// Depends on scs_pkg, scs_ctrl, scs_datapath and scs_ram.
//
// A transaction is taken when start is high and busy is low. Ticks and
// restarts return their result on done_o in the cycle after start; a read
// returns its result after the RAM read, the reciprocal multiply, the check
// multiplies, the remainder check, the pixel scaling multiply and the row
// rounding stage, one read at a time through one datapath. busy drops in the
// result cycle, so the next start can land there: a tick or restart every
// cycle, a read only after the last read's result. Results are shown for one
// cycle and cannot be held off. The sample store is not cleared at reset;
// only entries below the count captured since the last restart are valid.
`default_nettype none

module single_shot_sample_capture_scaler_core
  import scs_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  input  wire in_t                   in_i,
  output logic                       busy,
  output logic                       done_o,
  output out_t                       result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  scs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  scs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
